FILE: src/echo_presence_detector_defines.svh
// Assertion macros for the echo presence detector checker.
`ifndef ECHO_PRESENCE_DETECTOR_DEFINES_SVH
`define ECHO_PRESENCE_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define EPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define EPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/epd_pkg.sv
// Package: shared types and constants for the echo presence detector.
`timescale 1ns / 1ps
package epd_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_INTERVAL  = 2'd1,
    REG_PRES_DLY  = 2'd2,
    REG_ABS_DLY   = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] THRESHOLD_RST = 16'd10000;
  localparam logic [15:0] INTERVAL_RST  = 16'd100;
  localparam logic [31:0] PRES_DLY_RST  = 32'd2000;
  localparam logic [31:0] ABS_DLY_RST   = 32'd10000;

  // Out-of-range distance code, hundredths of a cm
  localparam logic [16:0] OUT_OF_RANGE_CENTI = 17'd99900;
  // Smallest echo whose distance exceeds 400 cm: floor(23530*17/10) = 40001
  localparam logic [14:0] ECHO_LIMIT = 15'd23530;
  // floor(e*17/10) == (e * 17 * ceil(2^22/10)) >> 22 for every e below ECHO_LIMIT
  localparam int          DIV_SHIFT  = 22;
  localparam logic [22:0] DIST_MULT  = 23'd7130327;

  typedef struct packed {
    logic [15:0] threshold_centi;
    logic [15:0] measure_interval_ms;
    logic [31:0] presence_delay_ms;
    logic [31:0] absence_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [16:0] distance_centi;
    logic        measured;
    logic        present;
    logic        changed;
  } result_t;

endpackage

FILE: src/epd_range.sv
// Echo pulse width to distance conversion in hundredths of a centimetre.
`timescale 1ns / 1ps
module epd_range
  import epd_pkg::*;
(
  input  logic [14:0] echo_us,
  output logic [16:0] distance_centi
);

  logic [37:0] product;
  logic [15:0] quotient;

  // Scale by 17/10 as one constant multiply and a shift
  assign product  = {23'd0, echo_us} * {15'd0, DIST_MULT};
  assign quotient = product[DIV_SHIFT +: 16];

  always_comb begin
    if (echo_us == 15'd0 || echo_us >= ECHO_LIMIT) begin
      distance_centi = OUT_OF_RANGE_CENTI;
    end else begin
      distance_centi = {1'b0, quotient};
    end
  end

endmodule

FILE: src/epd_core.sv
// Measurement cache, dwell timers and presence flag of the detector.
`timescale 1ns / 1ps
module epd_core
  import epd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [31:0] now_ms,
  input  logic [16:0] new_distance,
  input  cfg_t        cfg,
  output result_t     result
);

  logic [16:0] cached_distance, cached_distance_next;
  logic [31:0] last_measure_time, last_measure_time_next;
  logic        present_flag, present_flag_next;
  logic [31:0] arrive_start, arrive_start_next;
  logic        arrive_running, arrive_running_next;
  logic [31:0] leave_start, leave_start_next;
  logic        leave_running, leave_running_next;

  logic [31:0] since_measure;
  logic [31:0] since_arrive;
  logic [31:0] since_leave;
  logic        take;
  logic        near;
  logic        changed;
  logic [16:0] used_distance;

  // Differences wrap modulo 2^32
  assign since_measure = now_ms - last_measure_time;
  assign since_arrive  = now_ms - arrive_start;
  assign since_leave   = now_ms - leave_start;

  assign take          = since_measure >= {16'd0, cfg.measure_interval_ms};
  assign used_distance = take ? new_distance : cached_distance;
  assign near          = (used_distance != 17'd0) &&
                         (used_distance <= {1'b0, cfg.threshold_centi});

  always_comb begin
    cached_distance_next   = take ? new_distance : cached_distance;
    last_measure_time_next = take ? now_ms : last_measure_time;
    present_flag_next      = present_flag;
    arrive_start_next      = arrive_start;
    arrive_running_next    = arrive_running;
    leave_start_next       = leave_start;
    leave_running_next     = leave_running;
    changed                = 1'b0;
    if (near) begin
      leave_running_next = 1'b0;
      if (!present_flag) begin
        if (!arrive_running) begin
          arrive_start_next   = now_ms;
          arrive_running_next = 1'b1;
        end else if (since_arrive >= cfg.presence_delay_ms) begin
          present_flag_next   = 1'b1;
          arrive_running_next = 1'b0;
          changed             = 1'b1;
        end
      end
    end else begin
      arrive_running_next = 1'b0;
      if (present_flag) begin
        if (!leave_running) begin
          leave_start_next   = now_ms;
          leave_running_next = 1'b1;
        end else if (since_leave >= cfg.absence_delay_ms) begin
          present_flag_next  = 1'b0;
          leave_running_next = 1'b0;
          changed            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_distance   <= '0;
      last_measure_time <= '0;
      present_flag      <= 1'b0;
      arrive_start      <= '0;
      arrive_running    <= 1'b0;
      leave_start       <= '0;
      leave_running     <= 1'b0;
    end else if (step) begin
      cached_distance   <= cached_distance_next;
      last_measure_time <= last_measure_time_next;
      present_flag      <= present_flag_next;
      arrive_start      <= arrive_start_next;
      arrive_running    <= arrive_running_next;
      leave_start       <= leave_start_next;
      leave_running     <= leave_running_next;
    end
  end

  always_comb begin
    result.distance_centi = used_distance;
    result.measured       = take;
    result.present        = present_flag_next;
    result.changed        = changed;
  end

endmodule

FILE: src/echo_presence_detector.sv
// Top level of the ultrasonic echo presence detector with dwell timers.
// Usage:
//   Input channel (in_valid / in_stall) carries one presence check per item:
//   now_ms, a free-running millisecond timestamp, and echo_us, the echo pulse
//   width (0 for timeout). Output channel (out_valid / out_stall) returns one
//   item per check: distance used, whether this echo was measured, the
//   presence flag after the check and whether it toggled.
//   Path: an item taken into the input register passes through the range
//   conversion and core logic to the result register, which drives the output.
//   Throughput: one item per cycle while no result is stalled; the whole check
//   is a single pass of compare-and-update logic between the input register
//   and the result register, so each item sees the state left by the one
//   before it.
//   Stall: while out_stall holds a waiting result, the input register stays
//   put if full, or takes one more item if empty; in_stall rises only when
//   both registers are full.
//   Reset (rst, synchronous): clears both registers' valid bits, the cached
//   distance, the measurement time, both dwell timers and the presence flag,
//   and loads the default configuration.
//   Configuration: cfg_we writes cfg_data to register cfg_index; write only
//   while the block is idle.
`timescale 1ns / 1ps
module echo_presence_detector
  import epd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic [14:0] echo_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] distance_centi,
  output logic        measured,
  output logic        present,
  output logic        changed
);

  cfg_t        cfg;
  logic        stage_valid;
  logic [31:0] stage_now;
  logic [14:0] stage_echo;
  logic        advance;
  logic        in_take;
  logic [16:0] new_distance;
  result_t     step_result;
  result_t     result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_centi     <= THRESHOLD_RST;
      cfg.measure_interval_ms <= INTERVAL_RST;
      cfg.presence_delay_ms   <= PRES_DLY_RST;
      cfg.absence_delay_ms    <= ABS_DLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold_centi     <= cfg_data[15:0];
        REG_INTERVAL:  cfg.measure_interval_ms <= cfg_data[15:0];
        REG_PRES_DLY:  cfg.presence_delay_ms   <= cfg_data;
        REG_ABS_DLY:   cfg.absence_delay_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input register whenever the result register can take a new item
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // Payload needs no reset; hold it while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_now  <= now_ms;
      stage_echo <= echo_us;
    end
  end

  epd_range u_range (
    .echo_us        (stage_echo),
    .distance_centi (new_distance)
  );

  epd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .now_ms       (stage_now),
    .new_distance (new_distance),
    .cfg          (cfg),
    .result       (step_result)
  );

  // Result register: drop the item once taken, hold it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign distance_centi = result.distance_centi;
  assign measured       = result.measured;
  assign present        = result.present;
  assign changed        = result.changed;

endmodule

FILE: src/epd_checker.sv
// Port-level checker for the echo presence detector, bound to the top level.
`timescale 1ns / 1ps
`include "echo_presence_detector_defines.svh"
module epd_checker
  import epd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] distance_centi,
  input logic        measured,
  input logic        present,
  input logic        changed
);

  logic last_present;

  // Track the presence flag of the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_present <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_present <= present;
    end
  end

  `EPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance_centi) && $stable(measured) && $stable(present) && $stable(changed), "stalled result item changed")
  `EPD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no output back-pressure")
  `EPD_ASSERT_NOW(a_dist_range, out_valid, distance_centi <= 17'd40000 || distance_centi == OUT_OF_RANGE_CENTI, "distance outside legal range")
  `EPD_ASSERT_NOW(a_toggle, out_valid, (present != last_present) == changed, "presence toggle and changed flag disagree")

endmodule

bind echo_presence_detector epd_checker u_epd_checker (.*);
